// ----- hdl/dstk_pkg.sv -----
// Shared constants and codes for the descriptor similarity top-k search unit.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package dstk_pkg;

	// table geometry
	localparam int MAX_ENTRIES = 1024;
	localparam int DESC_LEN    = 512;
	localparam int MAX_TOPK    = 16;

	// threshold constants
	localparam int SIM_CAP   = 31130;  // 0.95 in Q1.15
	localparam int MIN_STATS = 10;

	// fixed field widths
	localparam int IDX_W      = 10;
	localparam int VAL_W      = 16;
	localparam int ST_W       = 2;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TOPK_REG_W = 5;
	localparam int EXCL_W     = 10;

	// derived widths
	localparam int ENT_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = ENT_W + 1;
	localparam int ELEM_W = $clog2(DESC_LEN);
	localparam int LEN_W  = ELEM_W + 1;
	localparam int ADDR_W = ENT_W + ELEM_W;
	localparam int LIST_W = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
	localparam int KCNT_W = $clog2(MAX_TOPK + 1);
	localparam int ACC_W  = 2 * VAL_W + LEN_W + 1;
	localparam int SUM_W  = VAL_W + CNT_W + 1;
	localparam int SQ_W   = 2 * VAL_W + CNT_W;
	localparam int D_W    = 2 * SUM_W;
	localparam int STEP_W = $clog2(D_W);
	localparam int MUL_W  = ((CNT_W > VAL_W) ? CNT_W : VAL_W) + 1;
	localparam int MP_W   = 2 * MUL_W;
	localparam int CMP_W  = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 2'd0,
		CMD_QUERY    = 2'd1,
		CMD_MARK_BAD = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOP_K   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIM = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/descriptor_similarity_topk_search_unit.sv -----
// Descriptor similarity top-k search: table, sequencer, shared multiplier,
// statistics, square root and top-k list. Depends on dstk_pkg.
//
// Usage:
//  Input channel (in_valid/in_stall) carries one command per request: add an
//  element (one per cycle while streaming a descriptor and in_stall is low),
//  query, mark bad, or clear. Results leave on the output channel
//  (out_valid/out_stall) from an output register; a query may give up to
//  MAX_TOPK results, the final one flagged by last. Every other command gives
//  at most one result. Configuration writes (cfg_valid/cfg_ready) are always
//  taken. Add, mark bad and clear give their result in the cycle after the
//  request is taken; an add element request without last gives none.
//  A query walks every present entry older than the query by more than the
//  exclude distance through one shared 17x17 multiplier at one element
//  product per cycle, then, when more than MIN_STATS scores exist, takes
//  2 * SUM_W serial-multiply steps and SUM_W square-root steps, then ranks
//  the entries, fetches the bad flags of the list slots and emits the
//  results. in_stall is high while a query runs and while a result waits
//  stalled. Reset clears the entry count, element pointer, list count and
//  valid registers and resets the configuration; the table memories have no
//  clearing pass. A stalled result holds its value.
`default_nettype none

module descriptor_similarity_topk_search_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// input request channel
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [dstk_pkg::CMD_W-1:0]           cmd,
	input  wire  signed [dstk_pkg::VAL_W-1:0]    element_value,
	input  wire                                  element_last,
	input  wire                                  descriptor_present,
	input  wire  [dstk_pkg::IDX_W-1:0]           entry_index,
	// result channel
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [dstk_pkg::ST_W-1:0]            status,
	output logic                                 candidate_valid,
	output logic [dstk_pkg::IDX_W-1:0]           candidate_index,
	output logic signed [dstk_pkg::VAL_W-1:0]    candidate_score,
	output logic                                 last,
	// configuration write channel
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [dstk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [dstk_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dstk_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_QCHK, S_LRD, S_LCHK, S_DOT, S_DEND, S_SQ1, S_SQ2,
		S_MUL, S_MEND, S_SQRT, S_BASE, S_P2RD, S_P2CHK, S_P2INS,
		S_BRD, S_BCAP, S_EMIT
	} state_t;

	typedef struct packed {
		logic [ST_W-1:0]         st;
		logic                    cvalid;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] score;
		logic                    lst;
	} out_t;

	localparam logic signed [VAL_W-1:0] SIM_CAP_V = VAL_W'(SIM_CAP);

	function automatic out_t mk_out(logic [ST_W-1:0] st, logic cv, logic [IDX_W-1:0] idx,
			logic signed [VAL_W-1:0] sc, logic lst);
		out_t o;
		o.st = st;
		o.cvalid = cv;
		o.idx = idx;
		o.score = sc;
		o.lst = lst;
		return o;
	endfunction

	function automatic logic signed [MUL_W-1:0] sx(logic signed [VAL_W-1:0] v);
		return {{(MUL_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	// control and configuration
	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	logic [LEN_W-1:0]           ptr_q;
	logic [TOPK_REG_W-1:0]      top_k_q;
	logic [EXCL_W-1:0]          excl_q;
	logic signed [VAL_W-1:0]    min_sim_q;

	// query walk
	logic [ENT_W-1:0]           q_q;
	logic [CNT_W-1:0]           lim_q;
	logic [ENT_W-1:0]           j_q;
	logic [LEN_W-1:0]           lenq_q;
	logic [LEN_W-1:0]           lenj_q;
	logic [LEN_W-1:0]           i_q;

	// dot-product pipeline
	logic                       v_s1;
	logic                       mask_s1;
	logic signed [VAL_W-1:0]    rda_s1;
	logic signed [VAL_W-1:0]    rdb_s1;
	logic                       v_s2;
	logic signed [MP_W-1:0]     mult_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [VAL_W-1:0]    score_q;

	// statistics
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic [CNT_W-1:0]           n_q;
	logic                       adapt_q;
	logic [D_W-1:0]             sm_acc_q;
	logic [D_W-1:0]             sm_mcand_q;
	logic [SUM_W-1:0]           sm_mpl_q;
	logic [STEP_W-1:0]          step_q;
	logic                       phase_q;
	logic [D_W-1:0]             nq_q;
	logic [D_W-1:0]             rt_v_q;
	logic [D_W-1:0]             rt_res_q;
	logic [D_W-1:0]             rt_bit_q;
	logic signed [MP_W-1:0]     base_q;

	// top-k list
	logic [ENT_W-1:0]           best_idx_q [MAX_TOPK];
	logic signed [VAL_W-1:0]    best_score_q [MAX_TOPK];
	logic [KCNT_W-1:0]          best_n_q;
	logic [KCNT_W-1:0]          b_q;
	logic [MAX_TOPK-1:0]        good_q;
	logic [LIST_W-1:0]          e_q;

	// output register
	logic                       out_valid_q;
	out_t                       out_q;

	// memories and read registers
	logic [VAL_W-1:0]           desc_mem [2**ADDR_W];
	logic [LEN_W-1:0]           len_mem [MAX_ENTRIES];
	logic                       bad_mem [MAX_ENTRIES];
	logic [VAL_W-1:0]           score_mem [MAX_ENTRIES];
	logic [LEN_W-1:0]           len_rd_q;
	logic [VAL_W-1:0]           score_rd_q;
	logic                       bad_rd_q;

	// combinational
	logic                       accept;
	logic                       out_free;
	logic                       full;
	logic [LEN_W-1:0]           ptr_next;
	logic [ENT_W-1:0]           cnt_ent;
	logic [ENT_W-1:0]           idx_ent;
	logic                       idx_ok;
	logic signed [CMP_W-1:0]    lim_calc;
	logic                       desc_we;
	logic                       commit;
	logic                       mark_ok;
	logic                       bad_we;
	logic [ENT_W-1:0]           bad_wa;
	logic                       len_re;
	logic [ENT_W-1:0]           len_ra;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [ACC_W-1:0]    acc_sh;
	logic signed [VAL_W-1:0]    score_new;
	logic [SUM_W-1:0]           sum_abs;
	logic signed [D_W:0]        d_calc;
	logic [D_W-1:0]             rt_t;
	logic [MP_W-1:0]            r3;
	logic signed [VAL_W-1:0]    s_p2;
	logic                       ok_p2;
	logic [MAX_TOPK-1:0]        ge;
	logic [KCNT_W-1:0]          pos;
	logic [KCNT_W-1:0]          k_eff;
	logic                       last_adv;
	logic [MAX_TOPK-1:0]        rest;
	logic                       emit_last;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;

	assign out_valid       = out_valid_q;
	assign status          = out_q.st;
	assign candidate_valid = out_q.cvalid;
	assign candidate_index = out_q.idx;
	assign candidate_score = out_q.score;
	assign last            = out_q.lst;

	// add and mark-bad decode
	always_comb begin
		full     = count_q >= CNT_W'(MAX_ENTRIES);
		ptr_next = (ptr_q < LEN_W'(DESC_LEN)) ? ptr_q + 1'b1 : ptr_q;
		cnt_ent  = count_q[ENT_W-1:0];
		idx_ent  = ENT_W'(entry_index);
		idx_ok   = CMP_W'(entry_index) < CMP_W'(count_q);
		lim_calc = $signed(CMP_W'(entry_index)) - $signed(CMP_W'(excl_q));
		desc_we  = accept && cmd == CMD_ADD && descriptor_present && !full
			&& ptr_q < LEN_W'(DESC_LEN);
		commit   = accept && cmd == CMD_ADD && !full
			&& (!descriptor_present || element_last);
		mark_ok  = accept && cmd == CMD_MARK_BAD && idx_ok;
		bad_we   = commit || mark_ok;
		bad_wa   = commit ? cnt_ent : idx_ent;
		len_re   = state_q == S_IDLE || state_q == S_LRD || state_q == S_P2RD;
		len_ra   = (state_q == S_IDLE) ? idx_ent : j_q;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DOT, S_DEND: begin
				mul_a = mask_s1 ? sx(rda_s1) : '0;
				mul_b = sx(rdb_s1);
			end
			S_SQ1: begin
				mul_a = sx(score_q);
				mul_b = sx(score_q);
			end
			S_P2CHK: begin
				mul_a = sx($signed(score_rd_q));
				mul_b = MUL_W'(n_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// score rounding, statistics and square root datapath
	always_comb begin
		acc_rnd = acc_q + ACC_W'(16384);
		acc_sh  = acc_rnd >>> 15;
		if (acc_sh > ACC_W'(32767))
			score_new = 16'sd32767;
		else if (acc_sh < -ACC_W'(32768))
			score_new = -16'sd32768;
		else
			score_new = acc_sh[VAL_W-1:0];
		sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		d_calc  = $signed({1'b0, nq_q}) - $signed({1'b0, sm_acc_q});
		rt_t    = rt_res_q + rt_bit_q;
		r3      = (MP_W'(rt_res_q[SUM_W-1:0]) << 1) + MP_W'(rt_res_q[SUM_W-1:0]);
	end

	// ranking pass: acceptance test and insert position
	always_comb begin
		s_p2 = $signed(score_rd_q);
		if (adapt_q)
			ok_p2 = (s_p2 >= SIM_CAP_V) || (s_p2 >= min_sim_q && mult_q >= base_q);
		else
			ok_p2 = s_p2 >= min_sim_q;
		for (int i = 0; i < MAX_TOPK; i++)
			ge[i] = (KCNT_W'(i) < best_n_q) && (best_score_q[i] >= s_p2);
		pos   = KCNT_W'($countones(ge));
		k_eff = (int'(top_k_q) > MAX_TOPK) ? KCNT_W'(MAX_TOPK) : KCNT_W'(top_k_q);
		last_adv  = (CNT_W'(j_q) + 1'b1) == lim_q;
		rest      = good_q >> e_q;
		emit_last = (rest >> 1) == '0;
	end

	// descriptor memory: one write port, two read ports
	always_ff @(posedge clk) begin
		if (desc_we)
			desc_mem[{cnt_ent, ptr_q[ELEM_W-1:0]}] <= element_value;
		rda_s1 <= $signed(desc_mem[{q_q, i_q[ELEM_W-1:0]}]);
		rdb_s1 <= $signed(desc_mem[{j_q, i_q[ELEM_W-1:0]}]);
	end

	// entry length memory; zero length means empty entry
	always_ff @(posedge clk) begin
		if (commit)
			len_mem[cnt_ent] <= descriptor_present ? ptr_next : '0;
		if (len_re)
			len_rd_q <= len_mem[len_ra];
	end

	// bad flag memory
	always_ff @(posedge clk) begin
		if (bad_we)
			bad_mem[bad_wa] <= !commit;
		bad_rd_q <= bad_mem[best_idx_q[b_q[LIST_W-1:0]]];
	end

	// score scratch memory
	always_ff @(posedge clk) begin
		if (state_q == S_DEND)
			score_mem[j_q] <= score_new;
		if (state_q == S_P2RD)
			score_rd_q <= score_mem[j_q];
	end

	// sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			top_k_q     <= TOPK_REG_W'(1);
			excl_q      <= '0;
			min_sim_q   <= '0;
			best_n_q    <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			// configuration
			if (cfg_valid) begin
				case (cfg_index)
					REG_TOP_K:   top_k_q   <= cfg_data[TOPK_REG_W-1:0];
					REG_EXCLUDE: excl_q    <= cfg_data[EXCL_W-1:0];
					REG_MIN_SIM: min_sim_q <= $signed(cfg_data[VAL_W-1:0]);
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			// dot-product pipeline
			v_s1    <= (state_q == S_DOT) && (i_q < LEN_W'(DESC_LEN));
			mask_s1 <= (i_q < lenq_q) && (i_q < lenj_q);
			v_s2    <= v_s1;
			mult_q  <= mul_a * mul_b;
			if (v_s2)
				acc_q <= acc_q + ACC_W'(mult_q);

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_ADD: begin
								if (!descriptor_present) begin
									ptr_q       <= '0;
									out_valid_q <= 1'b1;
									if (full)
										out_q <= mk_out(ST_FULL, 1'b0, '0, '0, 1'b1);
									else begin
										out_q   <= mk_out(ST_OK, 1'b0, IDX_W'(cnt_ent), '0, 1'b1);
										count_q <= count_q + 1'b1;
									end
								end else if (full) begin
									ptr_q <= '0;
									if (element_last) begin
										out_valid_q <= 1'b1;
										out_q <= mk_out(ST_FULL, 1'b0, '0, '0, 1'b1);
									end
								end else if (element_last) begin
									ptr_q       <= '0;
									out_valid_q <= 1'b1;
									out_q   <= mk_out(ST_OK, 1'b0, IDX_W'(cnt_ent), '0, 1'b1);
									count_q <= count_q + 1'b1;
								end else
									ptr_q <= ptr_next;
							end
							CMD_QUERY: begin
								if (!idx_ok) begin
									out_valid_q <= 1'b1;
									out_q <= mk_out(ST_INVALID, 1'b0, '0, '0, 1'b1);
								end else if (lim_calc <= 0) begin
									out_valid_q <= 1'b1;
									out_q <= mk_out(ST_OK, 1'b0, '0, '0, 1'b1);
								end else begin
									q_q     <= idx_ent;
									lim_q   <= CNT_W'(lim_calc);
									state_q <= S_QCHK;
								end
							end
							CMD_MARK_BAD: begin
								out_valid_q <= 1'b1;
								if (idx_ok)
									out_q <= mk_out(ST_OK, 1'b0, entry_index, '0, 1'b1);
								else
									out_q <= mk_out(ST_INVALID, 1'b0, '0, '0, 1'b1);
							end
							CMD_CLEAR: begin
								count_q     <= '0;
								ptr_q       <= '0;
								best_n_q    <= '0;
								out_valid_q <= 1'b1;
								out_q <= mk_out(ST_OK, 1'b0, '0, '0, 1'b1);
							end
							default: ;
						endcase
					end
				end

				// query entry must be present
				S_QCHK: begin
					if (len_rd_q == '0) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q   <= mk_out(ST_INVALID, 1'b0, '0, '0, 1'b1);
							state_q <= S_IDLE;
						end
					end else begin
						lenq_q  <= len_rd_q;
						j_q     <= '0;
						sum_q   <= '0;
						sq_q    <= '0;
						n_q     <= '0;
						state_q <= S_LRD;
					end
				end

				S_LRD: state_q <= S_LCHK;

				S_LCHK: begin
					if (len_rd_q != '0) begin
						lenj_q  <= len_rd_q;
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= S_DOT;
					end else if (!last_adv) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_LRD;
					end else if (n_q > CNT_W'(MIN_STATS)) begin
						adapt_q    <= 1'b1;
						sm_acc_q   <= '0;
						sm_mcand_q <= D_W'(sq_q);
						sm_mpl_q   <= SUM_W'(n_q);
						step_q     <= '0;
						phase_q    <= 1'b0;
						state_q    <= S_MUL;
					end else begin
						adapt_q  <= 1'b0;
						j_q      <= '0;
						best_n_q <= '0;
						state_q  <= S_P2RD;
					end
				end

				// one element product per cycle
				S_DOT: begin
					if (i_q < LEN_W'(DESC_LEN))
						i_q <= i_q + 1'b1;
					else if (!v_s1 && !v_s2)
						state_q <= S_DEND;
				end

				S_DEND: begin
					score_q <= score_new;
					sum_q   <= sum_q + SUM_W'(score_new);
					n_q     <= n_q + 1'b1;
					state_q <= S_SQ1;
				end

				S_SQ1: state_q <= S_SQ2;

				S_SQ2: begin
					sq_q <= sq_q + SQ_W'(mult_q);
					if (!last_adv) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_LRD;
					end else if (n_q > CNT_W'(MIN_STATS)) begin
						adapt_q    <= 1'b1;
						sm_acc_q   <= '0;
						sm_mcand_q <= D_W'(sq_q + SQ_W'(mult_q));
						sm_mpl_q   <= SUM_W'(n_q);
						step_q     <= '0;
						phase_q    <= 1'b0;
						state_q    <= S_MUL;
					end else begin
						adapt_q  <= 1'b0;
						j_q      <= '0;
						best_n_q <= '0;
						state_q  <= S_P2RD;
					end
				end

				// shift-add multiply, one multiplier bit per cycle
				S_MUL: begin
					if (sm_mpl_q[0])
						sm_acc_q <= sm_acc_q + sm_mcand_q;
					sm_mcand_q <= sm_mcand_q << 1;
					sm_mpl_q   <= sm_mpl_q >> 1;
					step_q     <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1))
						state_q <= S_MEND;
				end

				S_MEND: begin
					step_q <= '0;
					if (!phase_q) begin
						nq_q       <= sm_acc_q;
						sm_acc_q   <= '0;
						sm_mcand_q <= D_W'(sum_abs);
						sm_mpl_q   <= sum_abs;
						phase_q    <= 1'b1;
						state_q    <= S_MUL;
					end else begin
						rt_v_q   <= d_calc[D_W] ? '0 : d_calc[D_W-1:0];
						rt_res_q <= '0;
						rt_bit_q <= D_W'(1) << (D_W - 2);
						state_q  <= S_SQRT;
					end
				end

				// integer square root, one result bit per cycle
				S_SQRT: begin
					if (rt_v_q >= rt_t) begin
						rt_v_q   <= rt_v_q - rt_t;
						rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
					end else
						rt_res_q <= rt_res_q >> 1;
					rt_bit_q <= rt_bit_q >> 2;
					step_q   <= step_q + 1'b1;
					if (step_q == STEP_W'(D_W / 2 - 1))
						state_q <= S_BASE;
				end

				S_BASE: begin
					base_q   <= $signed(MP_W'(sum_q)) + $signed(r3);
					j_q      <= '0;
					best_n_q <= '0;
					state_q  <= S_P2RD;
				end

				S_P2RD: state_q <= S_P2CHK;

				S_P2CHK: begin
					if (len_rd_q != '0)
						state_q <= S_P2INS;
					else if (!last_adv) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_P2RD;
					end else begin
						b_q     <= '0;
						good_q  <= '0;
						state_q <= S_BRD;
					end
				end

				// sorted insert into the top-k list
				S_P2INS: begin
					if (ok_p2 && pos < k_eff) begin
						for (int i = MAX_TOPK - 1; i > 0; i--) begin
							if (KCNT_W'(i) > pos) begin
								best_idx_q[i]   <= best_idx_q[i-1];
								best_score_q[i] <= best_score_q[i-1];
							end
						end
						best_idx_q[pos[LIST_W-1:0]]   <= j_q;
						best_score_q[pos[LIST_W-1:0]] <= s_p2;
						if (best_n_q < k_eff)
							best_n_q <= best_n_q + 1'b1;
					end
					if (!last_adv) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_P2RD;
					end else begin
						b_q     <= '0;
						good_q  <= '0;
						state_q <= S_BRD;
					end
				end

				// fetch bad flags of the list entries
				S_BRD: begin
					if (b_q == best_n_q) begin
						e_q     <= '0;
						state_q <= S_EMIT;
					end else
						state_q <= S_BCAP;
				end

				S_BCAP: begin
					good_q[b_q[LIST_W-1:0]] <= !bad_rd_q;
					b_q     <= b_q + 1'b1;
					state_q <= S_BRD;
				end

				S_EMIT: begin
					if (good_q == '0) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q   <= mk_out(ST_OK, 1'b0, '0, '0, 1'b1);
							state_q <= S_IDLE;
						end
					end else if (good_q[e_q]) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q <= mk_out(ST_OK, 1'b1, IDX_W'(best_idx_q[e_q]),
								best_score_q[e_q], emit_last);
							if (emit_last)
								state_q <= S_IDLE;
							else
								e_q <= e_q + 1'b1;
						end
					end else
						e_q <= e_q + 1'b1;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dstk_checker.sv -----
// Port-level checker for the descriptor similarity top-k search unit.
// Depends on dstk_pkg; bound to the top level below.
`default_nettype none

module dstk_checker (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	input  wire                                  in_stall,
	input  wire  [dstk_pkg::CMD_W-1:0]           cmd,
	input  wire  signed [dstk_pkg::VAL_W-1:0]    element_value,
	input  wire                                  element_last,
	input  wire                                  descriptor_present,
	input  wire  [dstk_pkg::IDX_W-1:0]           entry_index,
	input  wire                                  out_valid,
	input  wire                                  out_stall,
	input  wire  [dstk_pkg::ST_W-1:0]            status,
	input  wire                                  candidate_valid,
	input  wire  [dstk_pkg::IDX_W-1:0]           candidate_index,
	input  wire  signed [dstk_pkg::VAL_W-1:0]    candidate_score,
	input  wire                                  last,
	input  wire                                  cfg_valid,
	input  wire                                  cfg_ready,
	input  wire  [dstk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [dstk_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dstk_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(candidate_index) && $stable(candidate_score) && $stable(last))
		else $error("stalled result changed");

	// a result with no candidate always closes its request
	a_nocand_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !candidate_valid |-> last)
		else $error("non-candidate result without last");

	// candidates only come with ok status
	a_cand_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && candidate_valid |-> status == ST_OK)
		else $error("candidate with error status");

	// error results carry no score
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !candidate_valid && candidate_score == '0)
		else $error("error result carries candidate data");

endmodule

bind descriptor_similarity_topk_search_unit dstk_checker u_dstk_checker (.*);

`default_nettype wire
